@@ src/bcuv_pkg.sv @@
`default_nettype none

package bcuv_pkg;

    // field geometry, fixed by the item layout
    localparam int COORD_BITS = 16;
    localparam int UV_BITS    = 16;
    localparam int RES_BITS   = 16;
    localparam int THR_BITS   = 32;

    // multiplier slice width for the wide products
    localparam int CHUNK_BITS = 24;

    // datapath widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int GRAM_W = 2 * DOT_W + 1;
    localparam int UVD_W  = UV_BITS + 1;
    localparam int MB_W   = UVD_W + GRAM_W;
    localparam int NUM_W  = MB_W + 2;
    localparam int QBITS  = RES_BITS + 1;
    localparam int DIV_W  = NUM_W + QBITS + 3;

    typedef enum logic [1:0] {
        OUTCOME_INTERP  = 2'd0,
        OUTCOME_DEGEN   = 2'd1,
        OUTCOME_INVALID = 2'd2
    } outcome_t;

    typedef struct packed {
        logic        triangle_valid;
        logic [47:0] corner_a;
        logic [47:0] corner_b;
        logic [47:0] corner_c;
        logic [31:0] uv_a;
        logic [31:0] uv_b;
        logic [31:0] uv_c;
        logic [47:0] query_point;
    } query_t;

    typedef struct packed {
        logic signed [RES_BITS-1:0] out_u;
        logic signed [RES_BITS-1:0] out_v;
        logic [1:0]                 outcome;
    } result_t;

endpackage

`default_nettype wire

@@ src/bcuv_mul.sv @@
`default_nettype none

// Signed multiplier, two register stages: sliced partial products, then their sum.
module bcuv_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic                     clk,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);
    import bcuv_pkg::*;

    localparam int NCH   = (B_W + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int BX_W  = NCH * CHUNK_BITS;
    localparam int PP_W  = A_W + CHUNK_BITS + 1;
    localparam int SUM_W = A_W + BX_W + 1;

    logic signed [BX_W-1:0]  bx;
    logic signed [PP_W-1:0]  pp_next [NCH];
    logic signed [PP_W-1:0]  pp_reg  [NCH];
    logic signed [SUM_W-1:0] acc;
    logic signed [A_W+B_W-1:0] p_reg;

    assign bx = BX_W'(b);

    // low slices are unsigned, the top slice carries the sign
    always_comb
    begin
        logic [CHUNK_BITS-1:0]      ch;
        logic signed [CHUNK_BITS:0] chx;
        for (int k = 0; k < NCH; k++)
        begin
            ch = bx[k*CHUNK_BITS +: CHUNK_BITS];
            if (k == NCH - 1)
                chx = {ch[CHUNK_BITS-1], ch};
            else
                chx = {1'b0, ch};
            pp_next[k] = a * chx;
        end
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < NCH; k++)
            acc = acc + (SUM_W'(pp_reg[k]) <<< (k * CHUNK_BITS));
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NCH; k++)
            pp_reg[k] <= pp_next[k];
        p_reg <= $signed(acc[A_W+B_W-1:0]);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ src/barycentric_uv_interpolate_core.sv @@
`default_nettype none

// Channel    | Ports                         | Beat
// -----------+-------------------------------+--------------------------------------
// query      | start, busy, query            | start high, busy low (busy never set)
// result     | done, result                  | done high for one cycle
// threshold  | cfg_valid, cfg_ready, cfg_data| valid and ready high (ready always set)
//
// One query enters every cycle.
// Path: 11 arithmetic stages, the 17-stage restoring divider, then the output register.
// Reset (rst_n, async low) clears the valid chain, the strobe and the threshold.
// No stalls on either side: the receiver cannot hold results off.
module barycentric_uv_interpolate_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bcuv_pkg::query_t query,
    output logic             done,
    output bcuv_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);
    import bcuv_pkg::*;

    localparam int DEPTH    = 11 + QBITS;
    localparam int LAT      = DEPTH + 1;
    localparam int DEGEN_AT = 6;
    localparam int UVP_LEN  = 7;
    localparam longint RES_MAX = 2**(RES_BITS-1) - 1;
    localparam longint RES_MIN = -(2**(RES_BITS-1));

    typedef struct packed {
        logic                       tri_ok;
        logic                       degen;
        logic signed [RES_BITS-1:0] su;
        logic signed [RES_BITS-1:0] sv;
    } side_t;

    typedef struct packed {
        logic signed [UV_BITS-1:0] au;
        logic signed [UV_BITS-1:0] av;
        logic signed [UVD_W-1:0]   d1u;
        logic signed [UVD_W-1:0]   d1v;
        logic signed [UVD_W-1:0]   d2u;
        logic signed [UVD_W-1:0]   d2v;
    } uvset_t;

    function automatic logic signed [RES_BITS-1:0] sat_res(
        input logic signed [UV_BITS-1:0] x
    );
        logic signed [63:0] xw;
        logic signed [RES_BITS-1:0] r;
        xw = 64'(x);
        if (xw > RES_MAX)
            r = RES_BITS'(RES_MAX);
        else if (xw < RES_MIN)
            r = RES_BITS'(RES_MIN);
        else
            r = RES_BITS'(xw);
        return r;
    endfunction

    // threshold register
    logic [THR_BITS-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // valid chain and sideband
    logic [DEPTH-1:0] vld_reg;
    side_t            side_reg [DEPTH];
    side_t            side_next;
    side_t            side_degen;
    logic             degen_next;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[DEPTH-2:0], start};
            done_reg <= vld_reg[DEPTH-1];
        end
    end

    always_comb
    begin
        side_degen       = side_reg[DEGEN_AT-1];
        side_degen.degen = side_reg[DEGEN_AT-1].tri_ok && degen_next;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < DEPTH; k++)
            side_reg[k] <= (k == DEGEN_AT) ? side_degen : side_reg[k-1];
    end

    // stage 1: unpack and edge differences
    logic signed [COORD_BITS-1:0] va [3];
    logic signed [COORD_BITS-1:0] vb [3];
    logic signed [COORD_BITS-1:0] vc [3];
    logic signed [COORD_BITS-1:0] vq [3];
    logic signed [UV_BITS-1:0]    ua, uva_v, ub, ubv, uc, ucv;
    logic signed [DIFF_W-1:0]     e1_reg [3];
    logic signed [DIFF_W-1:0]     e2_reg [3];
    logic signed [DIFF_W-1:0]     tp_reg [3];
    uvset_t                       uv_next;
    uvset_t                       uvp_reg [UVP_LEN];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va[k] = query.corner_a[k*COORD_BITS +: COORD_BITS];
            vb[k] = query.corner_b[k*COORD_BITS +: COORD_BITS];
            vc[k] = query.corner_c[k*COORD_BITS +: COORD_BITS];
            vq[k] = query.query_point[k*COORD_BITS +: COORD_BITS];
        end
        ua    = query.uv_a[0 +: UV_BITS];
        uva_v = query.uv_a[UV_BITS +: UV_BITS];
        ub    = query.uv_b[0 +: UV_BITS];
        ubv   = query.uv_b[UV_BITS +: UV_BITS];
        uc    = query.uv_c[0 +: UV_BITS];
        ucv   = query.uv_c[UV_BITS +: UV_BITS];

        uv_next.au  = ua;
        uv_next.av  = uva_v;
        uv_next.d1u = UVD_W'(ub) - UVD_W'(ua);
        uv_next.d1v = UVD_W'(ubv) - UVD_W'(uva_v);
        uv_next.d2u = UVD_W'(uc) - UVD_W'(ua);
        uv_next.d2v = UVD_W'(ucv) - UVD_W'(uva_v);

        side_next.tri_ok = query.triangle_valid;
        side_next.degen  = 1'b0;
        side_next.su     = sat_res(ua);
        side_next.sv     = sat_res(uva_v);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_reg[k] <= DIFF_W'(vb[k]) - DIFF_W'(va[k]);
            e2_reg[k] <= DIFF_W'(vc[k]) - DIFF_W'(va[k]);
            tp_reg[k] <= DIFF_W'(vq[k]) - DIFF_W'(va[k]);
        end
        uvp_reg[0] <= uv_next;
        for (int k = 1; k < UVP_LEN; k++)
            uvp_reg[k] <= uvp_reg[k-1];
    end

    // stage 2: per-axis products; stage 3: dot products
    logic signed [PROD_W-1:0] pbb_reg [3];
    logic signed [PROD_W-1:0] pbc_reg [3];
    logic signed [PROD_W-1:0] pcc_reg [3];
    logic signed [PROD_W-1:0] ppb_reg [3];
    logic signed [PROD_W-1:0] ppc_reg [3];
    logic signed [DOT_W-1:0]  bb_reg, bc_reg, cc_reg, pb_reg, pc_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pbb_reg[k] <= e1_reg[k] * e1_reg[k];
            pbc_reg[k] <= e1_reg[k] * e2_reg[k];
            pcc_reg[k] <= e2_reg[k] * e2_reg[k];
            ppb_reg[k] <= tp_reg[k] * e1_reg[k];
            ppc_reg[k] <= tp_reg[k] * e2_reg[k];
        end
        bb_reg <= DOT_W'(pbb_reg[0]) + DOT_W'(pbb_reg[1]) + DOT_W'(pbb_reg[2]);
        bc_reg <= DOT_W'(pbc_reg[0]) + DOT_W'(pbc_reg[1]) + DOT_W'(pbc_reg[2]);
        cc_reg <= DOT_W'(pcc_reg[0]) + DOT_W'(pcc_reg[1]) + DOT_W'(pcc_reg[2]);
        pb_reg <= DOT_W'(ppb_reg[0]) + DOT_W'(ppb_reg[1]) + DOT_W'(ppb_reg[2]);
        pc_reg <= DOT_W'(ppc_reg[0]) + DOT_W'(ppc_reg[1]) + DOT_W'(ppc_reg[2]);
    end

    // stages 4-5: Gram products
    logic signed [2*DOT_W-1:0] m_bbcc, m_bcbc, m_ccpb, m_bcpc, m_bbpc, m_bcpb;

    bcuv_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_bbcc (.clk(clk), .a(bb_reg), .b(cc_reg), .p(m_bbcc));
    bcuv_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_bcbc (.clk(clk), .a(bc_reg), .b(bc_reg), .p(m_bcbc));
    bcuv_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_ccpb (.clk(clk), .a(cc_reg), .b(pb_reg), .p(m_ccpb));
    bcuv_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_bcpc (.clk(clk), .a(bc_reg), .b(pc_reg), .p(m_bcpc));
    bcuv_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_bbpc (.clk(clk), .a(bb_reg), .b(pc_reg), .p(m_bbpc));
    bcuv_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_bcpb (.clk(clk), .a(bc_reg), .b(pb_reg), .p(m_bcpb));

    // stage 6: denominator and weight numerators
    logic signed [GRAM_W-1:0] den_s6_reg, nb_s6_reg, nc_s6_reg;

    always_ff @(posedge clk)
    begin
        den_s6_reg <= GRAM_W'(m_bbcc) - GRAM_W'(m_bcbc);
        nb_s6_reg  <= GRAM_W'(m_ccpb) - GRAM_W'(m_bcpc);
        nc_s6_reg  <= GRAM_W'(m_bbpc) - GRAM_W'(m_bcpb);
    end

    // stage 7: make the denominator positive, degeneracy test
    logic                     den_neg;
    logic signed [GRAM_W-1:0] den_abs;
    logic signed [GRAM_W-1:0] den_s7_reg, nb_s7_reg, nc_s7_reg;

    always_comb
    begin
        den_neg    = den_s6_reg[GRAM_W-1];
        den_abs    = den_neg ? -den_s6_reg : den_s6_reg;
        degen_next = $unsigned(den_abs) <= GRAM_W'(thr_reg);
    end

    always_ff @(posedge clk)
    begin
        den_s7_reg <= den_abs;
        nb_s7_reg  <= den_neg ? -nb_s6_reg : nb_s6_reg;
        nc_s7_reg  <= den_neg ? -nc_s6_reg : nc_s6_reg;
    end

    // stages 8-9: weighted texture terms
    logic signed [UVD_W-1:0] au_x, av_x;
    logic signed [MB_W-1:0]  mb_au, mb_bu, mb_cu, mb_av, mb_bv, mb_cv;

    assign au_x = UVD_W'(uvp_reg[UVP_LEN-1].au);
    assign av_x = UVD_W'(uvp_reg[UVP_LEN-1].av);

    bcuv_mul #(.A_W(UVD_W), .B_W(GRAM_W)) u_mul_au (.clk(clk), .a(au_x),
        .b(den_s7_reg), .p(mb_au));
    bcuv_mul #(.A_W(UVD_W), .B_W(GRAM_W)) u_mul_bu (.clk(clk), .a(uvp_reg[UVP_LEN-1].d1u),
        .b(nb_s7_reg), .p(mb_bu));
    bcuv_mul #(.A_W(UVD_W), .B_W(GRAM_W)) u_mul_cu (.clk(clk), .a(uvp_reg[UVP_LEN-1].d2u),
        .b(nc_s7_reg), .p(mb_cu));
    bcuv_mul #(.A_W(UVD_W), .B_W(GRAM_W)) u_mul_av (.clk(clk), .a(av_x),
        .b(den_s7_reg), .p(mb_av));
    bcuv_mul #(.A_W(UVD_W), .B_W(GRAM_W)) u_mul_bv (.clk(clk), .a(uvp_reg[UVP_LEN-1].d1v),
        .b(nb_s7_reg), .p(mb_bv));
    bcuv_mul #(.A_W(UVD_W), .B_W(GRAM_W)) u_mul_cv (.clk(clk), .a(uvp_reg[UVP_LEN-1].d2v),
        .b(nc_s7_reg), .p(mb_cv));

    logic signed [GRAM_W-1:0] den_s8_reg, den_s9_reg, den_s10_reg;
    logic signed [NUM_W-1:0]  num_reg [2];

    // stage 10: numerators
    always_ff @(posedge clk)
    begin
        den_s8_reg  <= den_s7_reg;
        den_s9_reg  <= den_s8_reg;
        den_s10_reg <= den_s9_reg;
        num_reg[0]  <= NUM_W'(mb_au) + NUM_W'(mb_bu) + NUM_W'(mb_cu);
        num_reg[1]  <= NUM_W'(mb_av) + NUM_W'(mb_bv) + NUM_W'(mb_cv);
    end

    // stage 11: rounding offset, (2|num| + den) / (2 den)
    logic [DIV_W-1:0] rem0_reg [2];
    logic             neg0_reg [2];
    logic [DIV_W-1:0] d2_0_reg;

    always_ff @(posedge clk)
    begin
        logic signed [NUM_W-1:0] mag;
        for (int l = 0; l < 2; l++)
        begin
            mag = num_reg[l][NUM_W-1] ? -num_reg[l] : num_reg[l];
            rem0_reg[l] <= (DIV_W'($unsigned(mag)) << 1) + DIV_W'($unsigned(den_s10_reg));
            neg0_reg[l] <= num_reg[l][NUM_W-1];
        end
        d2_0_reg <= DIV_W'($unsigned(den_s10_reg)) << 1;
    end

    // restoring divider, one quotient bit per stage, MSB first
    logic [DIV_W-1:0] rem_in   [2][QBITS];
    logic [QBITS-1:0] q_in     [2][QBITS];
    logic             ovf_in   [2][QBITS];
    logic             neg_in   [2][QBITS];
    logic [DIV_W-1:0] d2_in    [QBITS];
    logic [DIV_W-1:0] rem_next [2][QBITS];
    logic [QBITS-1:0] q_next   [2][QBITS];
    logic [DIV_W-1:0] rem_reg  [2][QBITS];
    logic [QBITS-1:0] q_reg    [2][QBITS];
    logic             ovf_reg  [2][QBITS];
    logic             neg_reg  [2][QBITS];
    logic [DIV_W-1:0] d2_reg   [QBITS];

    always_comb
    begin
        d2_in[0] = d2_0_reg;
        for (int s = 1; s < QBITS; s++)
            d2_in[s] = d2_reg[s-1];
        for (int l = 0; l < 2; l++)
        begin
            rem_in[l][0] = rem0_reg[l];
            q_in[l][0]   = '0;
            ovf_in[l][0] = rem0_reg[l] >= (d2_0_reg << QBITS);
            neg_in[l][0] = neg0_reg[l];
            for (int s = 1; s < QBITS; s++)
            begin
                rem_in[l][s] = rem_reg[l][s-1];
                q_in[l][s]   = q_reg[l][s-1];
                ovf_in[l][s] = ovf_reg[l][s-1];
                neg_in[l][s] = neg_reg[l][s-1];
            end
        end
    end

    always_comb
    begin
        logic [DIV_W-1:0] trial;
        for (int l = 0; l < 2; l++)
        begin
            for (int s = 0; s < QBITS; s++)
            begin
                trial = d2_in[s] << (QBITS - 1 - s);
                if (rem_in[l][s] >= trial)
                begin
                    rem_next[l][s] = rem_in[l][s] - trial;
                    q_next[l][s]   = q_in[l][s] | (QBITS'(1) << (QBITS - 1 - s));
                end
                else
                begin
                    rem_next[l][s] = rem_in[l][s];
                    q_next[l][s]   = q_in[l][s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QBITS; s++)
        begin
            d2_reg[s] <= d2_in[s];
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][s] <= rem_next[l][s];
                q_reg[l][s]   <= q_next[l][s];
                ovf_reg[l][s] <= ovf_in[l][s];
                neg_reg[l][s] <= neg_in[l][s];
            end
        end
    end

    // output: sign, saturation, outcome select
    logic signed [RES_BITS-1:0] res_q [2];
    result_t                    result_next;
    result_t                    result_reg;
    side_t                      side_out;

    assign side_out = side_reg[DEPTH-1];

    always_comb
    begin
        logic [QBITS-1:0] q;
        logic             ovf;
        for (int l = 0; l < 2; l++)
        begin
            q   = q_reg[l][QBITS-1];
            ovf = ovf_reg[l][QBITS-1];
            if (!neg_reg[l][QBITS-1])
                res_q[l] = (ovf || q > QBITS'(RES_MAX)) ? RES_BITS'(RES_MAX) : RES_BITS'(q);
            else
                res_q[l] = (ovf || q > QBITS'(-RES_MIN)) ? RES_BITS'(RES_MIN)
                                                         : RES_BITS'(-q);
        end

        priority if (!side_out.tri_ok)
        begin
            result_next.out_u   = '0;
            result_next.out_v   = '0;
            result_next.outcome = OUTCOME_INVALID;
        end
        else if (side_out.degen)
        begin
            result_next.out_u   = side_out.su;
            result_next.out_v   = side_out.sv;
            result_next.outcome = OUTCOME_DEGEN;
        end
        else
        begin
            result_next.out_u   = res_q[0];
            result_next.out_v   = res_q[1];
            result_next.outcome = OUTCOME_INTERP;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

    // a result beat follows each query beat through the valid chain and the done register
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without a query beat");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("query beat lost in the pipeline");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outcome == OUTCOME_INVALID) |-> (result.out_u == '0 && result.out_v == '0))
        else $error("invalid triangle gave a non-zero coordinate");

endmodule

`default_nettype wire
